// ===== sv/msw_pkg.sv =====
// Package for merge_sort_words: shared types for the front and back sections.
// No dependencies.
`default_nettype none
package msw_pkg;
    localparam int WORD_W = 32;

    typedef struct packed {
        logic [6:0] count;
        logic       dropped;
    } set_desc_t;
endpackage
`default_nettype wire

// ===== sv/msw_front.sv =====
// Front section: accept input beats, store words, classify last and overflow.
// Depends on msw_pkg. Hands a set descriptor to the back section.
`default_nettype none
module msw_front
    import msw_pkg::*;
#(
    parameter int MAX_ITEMS = 64,
    parameter int AW = 6
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [WORD_W-1:0]   value,
    input  wire logic                last,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [WORD_W-1:0]        wr_data,
    output logic                     desc_valid,
    output set_desc_t                desc,
    input  wire logic                desc_ready
);
    logic [6:0] count_reg, count_next;
    logic       drop_reg, drop_next;
    logic       busy_reg, busy_next;
    logic       full;
    logic       acc;

    // hold input while the back section still owns the word memory
    assign full     = (count_reg == 7'(MAX_ITEMS));
    assign in_ready = !busy_reg && desc_ready;
    assign acc      = in_valid && in_ready;
    assign wr_en    = acc && !full;
    assign wr_addr  = count_reg[AW-1:0];
    assign wr_data  = value;

    assign desc_valid   = busy_reg;
    assign desc.count   = count_reg;
    assign desc.dropped = drop_reg;

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        busy_next  = busy_reg;
        if (busy_reg && desc_ready)
        begin
            busy_next  = 1'b0;
            count_next = '0;
            drop_next  = 1'b0;
        end
        if (acc)
        begin
            if (full)
                drop_next = 1'b1;
            else
                count_next = count_reg + 7'd1;
            if (last)
                busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
            busy_reg  <= busy_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/msw_back.sv =====
// Back section: bottom-up merge passes between two word memories, then emit.
// Depends on msw_pkg. Owns both memories; the front writes through a port.
`default_nettype none
module msw_back
    import msw_pkg::*;
#(
    parameter int MAX_ITEMS = 64,
    parameter int AW = 6
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire logic [WORD_W-1:0]   wr_data,
    input  wire logic                desc_valid,
    input  wire set_desc_t           desc,
    output logic                     desc_ready,
    output logic [WORD_W-1:0]        value_res,
    output logic                     last_res,
    output logic                     overflowed,
    output logic                     out_valid,
    input  wire logic                out_ready
);
    typedef enum logic [2:0] {S_IDLE, S_RUN, S_READ, S_CMP, S_EMIT_RD, S_EMIT}
        state_t;

    logic [WORD_W-1:0] mem_a [MAX_ITEMS];
    logic [WORD_W-1:0] mem_b [MAX_ITEMS];

    state_t      state_reg;
    logic        src_b_reg;
    logic [6:0]  n_reg, width_reg, lo_reg, i_reg, j_reg, k_reg, mid_reg, hi_reg;
    logic        drop_reg;
    logic [WORD_W-1:0] ra_reg, rb_reg;
    logic [WORD_W-1:0] val_reg;
    logic        valid_reg, lastr_reg, ovfr_reg;

    logic [7:0]  mid_w, hi_w;
    logic        take_i;
    logic        i_ok, j_ok;
    logic        emit_fire;

    assign mid_w = {1'b0, lo_reg} + {1'b0, width_reg};
    assign hi_w  = ({1'b0, mid_w[6:0]} + {1'b0, width_reg} > {1'b0, n_reg})
                   ? {1'b0, n_reg} : mid_w + {1'b0, width_reg};
    assign i_ok  = i_reg < mid_reg;
    assign j_ok  = j_reg < hi_reg;
    assign take_i = i_ok && (!j_ok || ($signed(ra_reg) <= $signed(rb_reg)));
    assign emit_fire = (state_reg == S_EMIT) && (!valid_reg || out_ready);

    assign desc_ready = (state_reg == S_IDLE);
    assign value_res  = val_reg;
    assign last_res   = lastr_reg;
    assign overflowed = ovfr_reg;
    assign out_valid  = valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_a[wr_addr] <= wr_data;
        else if (state_reg == S_CMP)
        begin
            if (src_b_reg)
                mem_a[k_reg[AW-1:0]] <= take_i ? ra_reg : rb_reg;
            else
                mem_b[k_reg[AW-1:0]] <= take_i ? ra_reg : rb_reg;
        end
        if (state_reg == S_READ || state_reg == S_EMIT_RD)
        begin
            ra_reg <= src_b_reg ? mem_b[i_reg[AW-1:0]] : mem_a[i_reg[AW-1:0]];
            rb_reg <= src_b_reg ? mem_b[j_reg[AW-1:0]] : mem_a[j_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            src_b_reg <= 1'b0;
            n_reg <= '0; width_reg <= '0; lo_reg <= '0; i_reg <= '0;
            j_reg <= '0; k_reg <= '0; mid_reg <= '0; hi_reg <= '0;
            drop_reg <= 1'b0; lastr_reg <= 1'b0; val_reg <= '0;
            ovfr_reg <= 1'b0;
        end
        else
        begin
            if (emit_fire)
                valid_reg <= 1'b1;
            else if (valid_reg && out_ready)
                valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (desc_valid)
                    begin
                        n_reg     <= desc.count;
                        drop_reg  <= desc.dropped;
                        width_reg <= 7'd1;
                        lo_reg    <= '0;
                        src_b_reg <= 1'b0;
                        state_reg <= S_RUN;
                    end
                S_RUN:
                    if ({1'b0, width_reg} >= {1'b0, n_reg})
                    begin
                        i_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else if (mid_w >= {1'b0, n_reg})
                    begin
                        // copy tail run unchanged
                        if (lo_reg < n_reg)
                        begin
                            i_reg <= lo_reg; mid_reg <= n_reg;
                            j_reg <= n_reg;  hi_reg <= n_reg;
                            k_reg <= lo_reg;
                            lo_reg <= n_reg;
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            width_reg <= {width_reg[5:0], 1'b0};
                            lo_reg    <= '0;
                            src_b_reg <= !src_b_reg;
                        end
                    end
                    else
                    begin
                        i_reg <= lo_reg; mid_reg <= mid_w[6:0];
                        j_reg <= mid_w[6:0]; hi_reg <= hi_w[6:0];
                        k_reg <= lo_reg;
                        lo_reg <= hi_w[6:0];
                        state_reg <= S_READ;
                    end
                S_READ:
                    state_reg <= S_CMP;
                S_CMP:
                begin
                    if (take_i)
                        i_reg <= i_reg + 7'd1;
                    else
                        j_reg <= j_reg + 7'd1;
                    k_reg <= k_reg + 7'd1;
                    state_reg <= (k_reg + 7'd1 == hi_reg) ? S_RUN : S_READ;
                end
                S_EMIT_RD:
                    state_reg <= S_EMIT;
                S_EMIT:
                    if (emit_fire)
                    begin
                        val_reg   <= ra_reg;
                        lastr_reg <= (i_reg + 7'd1 == n_reg);
                        ovfr_reg  <= drop_reg;
                        i_reg     <= i_reg + 7'd1;
                        state_reg <= (i_reg + 7'd1 == n_reg) ? S_IDLE : S_EMIT_RD;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/merge_sort_words.sv =====
// merge_sort_words: collects signed 32-bit words until a beat with last set,
// sorts them ascending (stable bottom-up merge) and emits them in order.
//
// Input channel value/last with in_valid/in_ready; output channel
// value_res/last_res/overflowed with out_valid/out_ready. Up to MAX_ITEMS
// words are kept; further beats are dropped and overflowed is set on every
// result of that set. A last beat that finds the store full still ends it.
// Loading accepts one beat per cycle while in_ready is high. Sorting takes
// ceil(log2 n) passes; each word of a pass takes a memory read, then a
// compare and write, and each run begins with a setup step in S_RUN.
// Emission reads each word, then loads it into the output register. in_ready
// drops from the last beat until the back section has emitted the whole set.
// Reset clears counts and control; memories need no clearing. When the
// receiver stalls, the output register holds and emission waits.
`default_nettype none
module merge_sort_words
    import msw_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [31:0]  value,
    input  wire logic         last,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic [31:0]       value_res,
    output logic              last_res,
    output logic              overflowed,
    output logic              out_valid,
    input  wire logic         out_ready
);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [31:0]     wr_data;
    logic            desc_valid, desc_ready;
    set_desc_t       desc;

    msw_front #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_front (
        .clk(clk), .rst_n(rst_n), .value(value), .last(last),
        .in_valid(in_valid), .in_ready(in_ready),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .desc_valid(desc_valid), .desc(desc), .desc_ready(desc_ready)
    );

    msw_back #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .desc_valid(desc_valid), .desc(desc), .desc_ready(desc_ready),
        .value_res(value_res), .last_res(last_res), .overflowed(overflowed),
        .out_valid(out_valid), .out_ready(out_ready)
    );
endmodule
`default_nettype wire
